// ===== rtl/core/trwr_pkg.sv =====
// Package with the constants, types and helper functions of the trie root word replacer.
package trwr_pkg;

   // Trie dimensions.
   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;

   // Derived widths.
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int FREE_W     = NODE_W + 1;
   localparam int SYM_W      = 5;
   localparam int SLOT_COUNT = NODE_COUNT * ALPHABET_SIZE;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int ENTRY_W    = NODE_W + 1;

   // Operation codes of an input transaction.
   localparam logic OP_DICT     = 1'b0;
   localparam logic OP_SENTENCE = 1'b1;

   // Lookup side modes.
   typedef enum logic [1:0] {
      MODE_WALK,
      MODE_ECHO,
      MODE_SUPPRESS
   } lookup_mode_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } seq_state_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic              accept;
      logic              look;
      logic              clear_we;
      logic [SLOT_W-1:0] clear_addr;
   } seq_ctrl_type;

   // Child table slot of a node and a letter.
   function automatic logic [SLOT_W-1:0] slot_addr(input logic [NODE_W-1:0] node,
                                                   input logic [SYM_W-1:0]  sym);
      return SLOT_W'(SLOT_W'(node) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(sym));
   endfunction

   // True when the letter lies inside the alphabet.
   function automatic logic sym_in_alphabet(input logic [SYM_W-1:0] sym);
      return (32'(sym) < ALPHABET_SIZE);
   endfunction

endpackage

// ===== rtl/core/trwr_ram.sv =====
// Generic synchronous RAM with one write port and one registered read port.
module trwr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/trwr_seq.sv =====
// Sequencer: clearing pass after reset, then a lookup state for each accepted transaction.
module trwr_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output trwr_pkg::seq_ctrl_type ctrl
);

   trwr_pkg::seq_state_type        state_ff, state_in;
   logic [trwr_pkg::SLOT_W-1:0]    clear_ff, clear_in;

   // State and clear counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trwr_pkg::ST_CLEAR;
         clear_ff <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
      end
   end

   // Next state logic.
   always_comb begin
      state_in = state_ff;
      clear_in = clear_ff;
      case (state_ff)
         trwr_pkg::ST_CLEAR: begin
            clear_in = trwr_pkg::SLOT_W'(clear_ff + 1'b1);
            if (clear_ff == trwr_pkg::SLOT_W'(trwr_pkg::SLOT_COUNT - 1)) begin
               state_in = trwr_pkg::ST_IDLE;
            end
         end
         trwr_pkg::ST_IDLE: begin
            if (start) begin
               state_in = trwr_pkg::ST_LOOK;
            end
         end
         trwr_pkg::ST_LOOK: begin
            state_in = trwr_pkg::ST_IDLE;
         end
         default: begin
            state_in = trwr_pkg::ST_IDLE;
         end
      endcase
   end

   // Output logic.
   always_comb begin
      busy            = 1'b1;
      ctrl.accept     = 1'b0;
      ctrl.look       = 1'b0;
      ctrl.clear_we   = 1'b0;
      ctrl.clear_addr = clear_ff;
      case (state_ff)
         trwr_pkg::ST_CLEAR: begin
            ctrl.clear_we = 1'b1;
         end
         trwr_pkg::ST_IDLE: begin
            busy        = 1'b0;
            ctrl.accept = start;
         end
         trwr_pkg::ST_LOOK: begin
            ctrl.look = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/trie_root_word_replacer_unit.sv =====
// Top level of the trie root word replacer: child table memory, cursors and result register.
//
//   channel   ports                                    direction  handshake
//   request   req_operation, req_symbol, req_word_end  in         start high, busy low
//   response  rsp_out_symbol, rsp_out_word_end,        out        rsp_strobe, one cycle
//             rsp_dictionary_overflow
//
// The child table is read at the edge that accepts a transaction, and the entry is checked and
// written back in the following lookup cycle; busy is high then.
// A response appears on the cycle after the lookup cycle, so a new transaction may be
// accepted in the same cycle a response is shown. Dictionary letters give no response.
// After reset a clearing pass zeroes all 26624 slots of the child table; busy is high then.
// The receiver cannot stall; responses are never held back.
module trie_root_word_replacer_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_operation,
   input  logic [trwr_pkg::SYM_W-1:0] req_symbol,
   input  logic                       req_word_end,
   output logic                       rsp_strobe,
   output logic [trwr_pkg::SYM_W-1:0] rsp_out_symbol,
   output logic                       rsp_out_word_end,
   output logic                       rsp_dictionary_overflow
);

   trwr_pkg::seq_ctrl_type ctrl;

   // Latched transaction.
   logic                          op_ff;
   logic [trwr_pkg::SYM_W-1:0]    sym_ff;
   logic                          end_ff;
   logic                          sym_ok_ff;
   logic [trwr_pkg::SLOT_W-1:0]   slot_ff;

   // Trie walking state.
   logic [trwr_pkg::NODE_W-1:0]   insert_cursor_ff, insert_cursor_in;
   logic                          insert_stopped_ff, insert_stopped_in;
   logic [trwr_pkg::FREE_W-1:0]   next_free_ff, next_free_in;
   logic [trwr_pkg::NODE_W-1:0]   lookup_cursor_ff, lookup_cursor_in;
   trwr_pkg::lookup_mode_type     lookup_mode_ff, lookup_mode_in;
   logic                          overflow_ff, overflow_in;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [trwr_pkg::SYM_W-1:0]    rsp_sym_ff;
   logic                          rsp_end_ff, rsp_end_in;
   logic                          rsp_ovf_ff;

   // Memory ports.
   logic                          req_sym_ok;
   logic [trwr_pkg::NODE_W-1:0]   req_node;
   logic [trwr_pkg::SLOT_W-1:0]   ram_raddr;
   logic [trwr_pkg::ENTRY_W-1:0]  ram_rdata;
   logic                          ram_we;
   logic [trwr_pkg::SLOT_W-1:0]   ram_waddr;
   logic [trwr_pkg::ENTRY_W-1:0]  ram_wdata;
   logic                          dp_we;
   logic [trwr_pkg::ENTRY_W-1:0]  dp_wdata;

   // Decoded entry and insertion scratch values.
   logic [trwr_pkg::NODE_W-1:0]   entry_child;
   logic                          entry_root;
   logic                          stop_v;
   logic [trwr_pkg::NODE_W-1:0]   nxt_v;
   logic                          root_v;
   logic                          alloc_v;
   logic                          mark_v;

   trwr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   // Each entry holds the child node and the root mark of that child.
   trwr_ram #(
      .WIDTH (trwr_pkg::ENTRY_W),
      .DEPTH (trwr_pkg::SLOT_COUNT)
   ) u_child_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ctrl.accept),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Read address of the accepted letter; letters outside the alphabet read slot zero.
   always_comb begin
      req_sym_ok = trwr_pkg::sym_in_alphabet(req_symbol);
      req_node   = (req_operation == trwr_pkg::OP_SENTENCE) ? lookup_cursor_ff
                                                            : insert_cursor_ff;
      ram_raddr  = req_sym_ok ? trwr_pkg::slot_addr(req_node, req_symbol) : '0;
   end

   // The clearing pass owns the write port until it finishes.
   always_comb begin
      if (ctrl.clear_we) begin
         ram_we    = 1'b1;
         ram_waddr = ctrl.clear_addr;
         ram_wdata = '0;
      end else begin
         ram_we    = dp_we;
         ram_waddr = slot_ff;
         ram_wdata = dp_wdata;
      end
   end

   assign entry_child = ram_rdata[trwr_pkg::NODE_W-1:0];
   assign entry_root  = ram_rdata[trwr_pkg::NODE_W];

   // Lookup cycle: insert or walk with the entry just read.
   always_comb begin
      insert_cursor_in  = insert_cursor_ff;
      insert_stopped_in = insert_stopped_ff;
      next_free_in      = next_free_ff;
      lookup_cursor_in  = lookup_cursor_ff;
      lookup_mode_in    = lookup_mode_ff;
      overflow_in       = overflow_ff;
      rsp_valid_in      = 1'b0;
      rsp_end_in        = end_ff;
      dp_we             = 1'b0;
      dp_wdata          = '0;
      stop_v            = insert_stopped_ff;
      nxt_v             = entry_child;
      root_v            = entry_root;
      alloc_v           = 1'b0;
      mark_v            = 1'b0;
      if (ctrl.look) begin
         if (op_ff == trwr_pkg::OP_DICT) begin
            if (!insert_stopped_ff) begin
               if (!sym_ok_ff) begin
                  stop_v = 1'b1;
               end else begin
                  // A missing child takes the next free node if the pool has one.
                  if (entry_child == '0) begin
                     if (next_free_ff < trwr_pkg::FREE_W'(trwr_pkg::NODE_COUNT)) begin
                        nxt_v        = next_free_ff[trwr_pkg::NODE_W-1:0];
                        root_v       = 1'b0;
                        alloc_v      = 1'b1;
                        next_free_in = trwr_pkg::FREE_W'(next_free_ff + 1'b1);
                     end else begin
                        overflow_in = 1'b1;
                        stop_v      = 1'b1;
                     end
                  end
                  if (!stop_v) begin
                     insert_cursor_in = nxt_v;
                     if (root_v) begin
                        stop_v = 1'b1;
                     end
                  end
                  // The root mark lives in the slot that points to the marked node.
                  mark_v   = end_ff && !stop_v;
                  dp_we    = alloc_v || mark_v;
                  dp_wdata = {mark_v, nxt_v};
               end
            end
            insert_stopped_in = stop_v;
            if (end_ff) begin
               insert_cursor_in  = '0;
               insert_stopped_in = 1'b0;
            end
         end else begin
            case (lookup_mode_ff)
               trwr_pkg::MODE_WALK: begin
                  rsp_valid_in = 1'b1;
                  if (!sym_ok_ff || entry_child == '0) begin
                     lookup_mode_in = trwr_pkg::MODE_ECHO;
                  end else begin
                     lookup_cursor_in = entry_child;
                     if (entry_root) begin
                        lookup_mode_in = trwr_pkg::MODE_SUPPRESS;
                        rsp_end_in     = 1'b1;
                     end
                  end
               end
               trwr_pkg::MODE_ECHO: begin
                  rsp_valid_in = 1'b1;
               end
               default: begin
                  rsp_valid_in = 1'b0;
               end
            endcase
            if (end_ff) begin
               lookup_cursor_in = '0;
               lookup_mode_in   = trwr_pkg::MODE_WALK;
            end
         end
      end
   end

   // Transaction latch.
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         op_ff     <= req_operation;
         sym_ff    <= req_symbol;
         end_ff    <= req_word_end;
         sym_ok_ff <= req_sym_ok;
         slot_ff   <= ram_raddr;
      end
   end

   // Walking state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         insert_cursor_ff  <= '0;
         insert_stopped_ff <= 1'b0;
         next_free_ff      <= trwr_pkg::FREE_W'(1);
         lookup_cursor_ff  <= '0;
         lookup_mode_ff    <= trwr_pkg::MODE_WALK;
         overflow_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         insert_cursor_ff  <= insert_cursor_in;
         insert_stopped_ff <= insert_stopped_in;
         next_free_ff      <= next_free_in;
         lookup_cursor_ff  <= lookup_cursor_in;
         lookup_mode_ff    <= lookup_mode_in;
         overflow_ff       <= overflow_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Response payload; the flag shows the value before this letter.
   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_sym_ff <= sym_ff;
         rsp_end_ff <= rsp_end_in;
         rsp_ovf_ff <= overflow_ff;
      end
   end

   assign rsp_strobe              = rsp_valid_ff;
   assign rsp_out_symbol          = rsp_sym_ff;
   assign rsp_out_word_end        = rsp_end_ff;
   assign rsp_dictionary_overflow = rsp_ovf_ff;

endmodule

// ===== rtl/core/trwr_checker.sv =====
// Port-level checker of the trie root word replacer and its bind statement.
module trwr_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_operation,
   input logic rsp_strobe
);

   // An accepted transaction occupies the block in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after an accepted transaction");

   // Every response comes from an accepted transaction, with its lookup state between the two.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without an accepted transaction");

   // A dictionary letter never gives a response.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == trwr_pkg::OP_DICT)) |-> ##2 !rsp_strobe)
      else $error("response for a dictionary letter");

   // Responses never come on consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("responses on consecutive cycles");

endmodule

bind trie_root_word_replacer_unit trwr_checker u_trwr_checker (.*);
